// ===== src/blid_pkg.sv =====
`timescale 1ns / 1ps

package blid_pkg;

	// word and list geometry
	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;
	localparam int DEPTH_MAX = 64;
	localparam int IDX_W     = 6;    // holds any cell index up to DEPTH_MAX - 1
	localparam int POS_W     = 8;
	localparam int CNT_OUT_W = 7;

	// command codes
	localparam logic [2:0] CMD_CLEAR    = 3'd0;
	localparam logic [2:0] CMD_PUSH     = 3'd1;
	localparam logic [2:0] CMD_DEL_HEAD = 3'd2;
	localparam logic [2:0] CMD_DEL_TAIL = 3'd3;
	localparam logic [2:0] CMD_DEL_POS  = 3'd4;
	localparam logic [2:0] CMD_DUMP     = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOPOS   = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// word that is never stored
	localparam logic signed [DATA_W-1:0] END_MARK = -32'sd1;

	// per-cycle move of the cell row
	typedef enum logic [1:0] {
		OP_HOLD,   // keep word
		OP_SHR,    // take left neighbor (push at head)
		OP_SHL,    // cells at or after idx take right neighbor
		OP_ROT     // cells before idx take right neighbor, cell idx takes head
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [IDX_W-1:0]   idx;
	} cell_ctl_t;

endpackage

// ===== src/blid_cell.sv =====
`timescale 1ns / 1ps

module blid_cell #(
	parameter int IDX = 0
) (
	input  logic                                  clk,
	input  blid_pkg::cell_ctl_t                   ctl,
	input  logic signed [blid_pkg::DATA_W-1:0]    left_data,
	input  logic signed [blid_pkg::DATA_W-1:0]    right_data,
	input  logic signed [blid_pkg::DATA_W-1:0]    head_data,
	output logic signed [blid_pkg::DATA_W-1:0]    data
);
	import blid_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic signed [DATA_W-1:0] word_q;

	// word update from the neighbors
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_SHR: begin
				word_q <= left_data;
			end
			OP_SHL: begin
				if (MY_IDX >= ctl.idx) begin
					word_q <= right_data;
				end
			end
			OP_ROT: begin
				if (MY_IDX == ctl.idx) begin
					word_q <= head_data;
				end else if (MY_IDX < ctl.idx) begin
					word_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = word_q;

endmodule

// ===== src/bounded_list_insert_delete_core.sv =====
`timescale 1ns / 1ps

// Bounded ordered list of up to DEPTH signed 32-bit words held in a row of
// shifting cells, head in cell 0. Clear, push at head and the three deletes
// are accepted one per cycle while the output register is free and answer
// with one result each; an edit that moves entries is a single shift of the
// cell row. Dump answers with one result per held entry, head first, flagged
// last on the final one, by rotating the held part of the row one cell per
// cycle while the output register is free, and no request is taken
// meanwhile; an empty list gives a single empty result. Push on a full list
// reports full, a push of -1 is ignored, position 0 deletes the second entry
// and a position past the end leaves the list unchanged. Commands 6 and 7
// are accepted and give no result. A result waits in an output register;
// the next request is accepted in the cycle that result is taken.
module bounded_list_insert_delete_core #(
	parameter int DEPTH = blid_pkg::DEPTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [2:0]                               cmd,
	input  logic signed [blid_pkg::DATA_W-1:0]       value,
	input  logic [blid_pkg::POS_W-1:0]               position,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [2:0]                               status,
	output logic signed [blid_pkg::DATA_W-1:0]       removed_value,
	output logic signed [blid_pkg::DATA_W-1:0]       data,
	output logic [blid_pkg::CNT_OUT_W-1:0]           count,
	output logic                                     last
);
	import blid_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rem_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic signed [DATA_W-1:0] removed_q;
	logic signed [DATA_W-1:0] data_q;
	logic [CNT_OUT_W-1:0]     count_out_q;
	logic              last_q;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	cell_ctl_t         ctl;

	logic              out_free;
	logic              accept;
	logic              dump_step;
	logic [IW-1:0]     last_idx;
	logic [POS_W-1:0]  pos_idx;
	logic [POS_W-1:0]  cnt_pos;

	// result of the request at hand
	logic              emit;
	logic [2:0]        res_status;
	logic signed [DATA_W-1:0] res_removed;
	logic signed [DATA_W-1:0] res_data;
	logic              res_last;
	logic [CW-1:0]     nxt_count;
	logic              go_dump;

	// handshake
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign dump_step = (state_q == S_DUMP) && out_free;

	assign last_idx = IW'(count_q - 1'b1);
	assign pos_idx  = (position == '0) ? POS_W'(1) : position - 1'b1;
	assign cnt_pos  = POS_W'(count_q);

	// command decode and cell row control
	always_comb begin
		emit        = 1'b0;
		res_status  = ST_OK;
		res_removed = '0;
		res_data    = '0;
		res_last    = 1'b1;
		nxt_count   = count_q;
		go_dump     = 1'b0;
		ctl.op      = OP_HOLD;
		ctl.idx     = IDX_W'(last_idx);
		if (dump_step) begin
			emit     = 1'b1;
			res_data = cell_data[0];
			res_last = (rem_q == CW'(1));
			ctl.op   = OP_ROT;
		end else if (accept) begin
			unique case (cmd)
				CMD_CLEAR: begin
					emit      = 1'b1;
					nxt_count = '0;
				end
				CMD_PUSH: begin
					emit = 1'b1;
					if (value == END_MARK) begin
						res_status = ST_IGNORED;
					end else if (count_q >= FULL_CNT) begin
						res_status = ST_FULL;
					end else begin
						ctl.op    = OP_SHR;
						nxt_count = count_q + 1'b1;
					end
				end
				CMD_DEL_HEAD: begin
					emit = 1'b1;
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						res_removed = cell_data[0];
						ctl.op      = OP_SHL;
						ctl.idx     = '0;
						nxt_count   = count_q - 1'b1;
					end
				end
				CMD_DEL_TAIL: begin
					emit = 1'b1;
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						res_removed = cell_data[last_idx];
						nxt_count   = count_q - 1'b1;
					end
				end
				CMD_DEL_POS: begin
					emit = 1'b1;
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else if (pos_idx >= cnt_pos) begin
						res_status = ST_NOPOS;
					end else begin
						ctl.op    = OP_SHL;
						ctl.idx   = IDX_W'(pos_idx);
						nxt_count = count_q - 1'b1;
					end
				end
				CMD_DUMP: begin
					emit = 1'b1;
					if (count_q == '0) begin
						res_status = ST_EMPTY;
					end else begin
						res_data = cell_data[0];
						res_last = (count_q == CW'(1));
						go_dump  = (count_q != CW'(1));
						ctl.op   = OP_ROT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_w = cell_data[i];
		end else begin : g_inner
			assign right_w = cell_data[i+1];
		end
		blid_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.left_data  (left_w),
			.right_data (right_w),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	// state, count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			removed_q   <= '0;
			data_q      <= '0;
			count_out_q <= '0;
			last_q      <= 1'b0;
		end else begin
			count_q <= nxt_count;
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				status_q    <= res_status;
				removed_q   <= res_removed;
				data_q      <= res_data;
				count_out_q <= CNT_OUT_W'(nxt_count);
				last_q      <= res_last;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go_dump) begin
						state_q <= S_DUMP;
						rem_q   <= count_q - 1'b1;
					end
				end
				S_DUMP: begin
					if (dump_step) begin
						rem_q <= rem_q - 1'b1;
						if (res_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign data          = data_q;
	assign count         = count_out_q;
	assign last          = last_q;

`ifndef SYNTH
	// list never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	// a result without last only appears while a dump is streaming
	a_last_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (state_q == S_DUMP))
		else $error("non-final result outside dump");

	// dump leaves the count alone
	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> (count_q == $past(count_q)))
		else $error("count changed during dump");

	// a storing push grows the list by one
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd == CMD_PUSH) && (value != END_MARK) && (count_q < FULL_CNT))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not grow list");
`endif

endmodule
